// ===== rtl/rptu_pkg.sv =====
// Shared types and constants of the row-to-page bit transpose unit.
// No dependencies; the front end, queue, back end, top level and testbench refer to it by scoped names.
package rptu_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int MAX_STRIDE  = 64;
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes (byte address is 4 * index)
    localparam logic [1:0] REG_WINDOW_WIDTH  = 2'd0;
    localparam logic [1:0] REG_WINDOW_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LINE_STRIDE   = 2'd2;

    // Clamped and derived configuration seen by the front end
    typedef struct packed {
        logic [8:0] width;      // 1..256
        logic [7:0] height_m1;  // last window row
        logic [5:0] tight;      // data bytes per row, 1..32
        logic [6:0] stride;     // bytes per row incl. padding, 1..64
    } t_cfg;

    // One final-row byte handed to the back end
    typedef struct packed {
        logic [63:0] rows;      // row k of the page in bits 8k+7..8k
        logic [4:0]  base;      // byte position; columns start at 8*base
        logic [4:0]  page;
        logic [2:0]  ncols_m1;  // columns to emit minus one
        logic        last;      // window ends on the final column of this job
    } t_job;

    typedef struct packed {
        logic [2:0] count;
        logic       empty;
    } t_q_stat;

endpackage

// ===== rtl/rptu_in_if.sv =====
// Input channel of the transpose unit: one source pixel byte per transfer.
// Depends on nothing.
interface rptu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;

    modport source (output valid, output pixel_byte, input ready);
    modport sink   (input valid, input pixel_byte, output ready);
endinterface

// ===== rtl/rptu_out_if.sv =====
// Output channel of the transpose unit: one vertical page byte per transfer.
// Depends on nothing.
interface rptu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] page_byte;
    logic [7:0] column;
    logic [4:0] page;
    logic       last;

    modport source (output valid, output page_byte, output column, output page,
                    output last, input ready);
    modport sink   (input valid, input page_byte, input column, input page,
                    input last, output ready);
endinterface

// ===== rtl/rptu_front.sv =====
// Front end: accepts pixel bytes, tracks row/page position, stores the upper
// rows of a page and forwards final-row bytes as jobs. Uses rptu_pkg, rptu_in_if.
module rptu_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rptu_pkg::t_cfg   i_cfg,
    input  rptu_pkg::t_q_stat i_q_stat,
    rptu_in_if.sink          i_pix,
    output logic             o_push,
    output rptu_pkg::t_job   o_job
);

    logic [55:0] r_mem [rptu_pkg::MAX_STRIDE];

    logic [2:0] r_row, n_row;
    logic [4:0] r_page, n_page;
    logic [5:0] r_byte, n_byte;

    logic        r_s1_valid;
    logic [55:0] r_rd_data;
    logic [7:0]  r_s1_byte;
    logic [2:0]  r_s1_row;
    logic [4:0]  r_s1_base;
    logic [4:0]  r_s1_page;
    logic [2:0]  r_s1_ncm1;
    logic        r_s1_last;

    logic        accept;
    logic        last_row;
    logic        final_row;
    logic        data_byte;
    logic        end_of_row;
    logic [8:0]  rem;
    logic [2:0]  ncm1;
    logic [55:0] masked;

    assign i_pix.ready = ({1'b0, i_q_stat.count} + {3'b0, r_s1_valid})
                         < 4'(rptu_pkg::QUEUE_DEPTH);
    assign accept      = i_pix.valid & i_pix.ready;

    assign last_row   = {r_page, r_row} >= i_cfg.height_m1;
    assign final_row  = (r_row == 3'd7) | last_row;
    assign data_byte  = r_byte < i_cfg.tight;
    assign end_of_row = ({1'b0, r_byte} + 7'd1) >= i_cfg.stride;
    assign rem        = i_cfg.width - {1'b0, r_byte[4:0], 3'b000};
    assign ncm1       = (rem >= 9'd8) ? 3'd7 : (rem[2:0] - 3'd1);

    always_comb begin
        n_row  = r_row;
        n_page = r_page;
        n_byte = r_byte + 6'd1;
        if (end_of_row) begin
            n_byte = '0;
            if (final_row) begin
                n_row  = '0;
                n_page = last_row ? 5'd0 : r_page + 5'd1;
            end else begin
                n_row = r_row + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_page     <= '0;
            r_byte     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept & data_byte & final_row;
            if (accept) begin
                r_row  <= n_row;
                r_page <= n_page;
                r_byte <= n_byte;
            end
        end
    end

    // Row store: write one row lane, or read the whole entry for a final row
    always_ff @(posedge i_clk) begin
        if (accept && data_byte) begin
            if (final_row) begin
                r_rd_data <= r_mem[r_byte];
            end else begin
                r_mem[r_byte][{r_row, 3'b000} +: 8] <= i_pix.pixel_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_byte <= i_pix.pixel_byte;
            r_s1_row  <= r_row;
            r_s1_base <= r_byte[4:0];
            r_s1_page <= r_page;
            r_s1_ncm1 <= ncm1;
            r_s1_last <= last_row & (r_byte == i_cfg.tight - 6'd1);
        end
    end

    // Drop stale lanes from rows at or below the current one
    always_comb begin
        for (int k = 0; k < 7; k++) begin
            masked[8*k +: 8] = (3'(k) < r_s1_row) ? r_rd_data[8*k +: 8] : 8'd0;
        end
    end

    assign o_push          = r_s1_valid;
    assign o_job.rows      = {8'd0, masked} | ({56'd0, r_s1_byte} << {r_s1_row, 3'b000});
    assign o_job.base      = r_s1_base;
    assign o_job.page      = r_s1_page;
    assign o_job.ncols_m1  = r_s1_ncm1;
    assign o_job.last      = r_s1_last;

endmodule

// ===== rtl/rptu_queue.sv =====
// Short job queue between the front and back ends.
// Uses rptu_pkg for the job and status types.
module rptu_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rptu_pkg::t_job    i_job,
    input  logic              i_pop,
    output rptu_pkg::t_job    o_head,
    output rptu_pkg::t_q_stat o_stat
);

    rptu_pkg::t_job r_slot [rptu_pkg::QUEUE_DEPTH];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 2'd1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 2'd1;
            r_count <= r_count + {2'b0, i_push} - {2'b0, i_pop};
        end
    end

    assign o_head       = r_slot[r_rd_ptr];
    assign o_stat.count = r_count;
    assign o_stat.empty = (r_count == 3'd0);

endmodule

// ===== rtl/rptu_back.sv =====
// Back end: serializes each job into one page byte per column through an
// output register. Uses rptu_pkg and rptu_out_if.
module rptu_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rptu_pkg::t_job    i_head,
    input  rptu_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    rptu_out_if.source        o_page
);

    logic       r_out_valid;
    logic [7:0] r_page_byte;
    logic [7:0] r_column;
    logic [4:0] r_page;
    logic       r_last;
    logic [2:0] r_col_idx;

    logic       advance;
    logic       emit;
    logic       job_done;
    logic [7:0] col_bits;
    logic [7:0] lane;

    assign advance  = ~r_out_valid | o_page.ready;
    assign emit     = advance & ~i_q_stat.empty;
    assign job_done = (r_col_idx == i_head.ncols_m1);
    assign o_pop    = emit & job_done;

    // Column idx of row k sits at bit 7-idx of that row's byte
    always_comb begin
        lane = '0;
        for (int k = 0; k < 8; k++) begin
            lane        = i_head.rows[8*k +: 8];
            col_bits[k] = lane[3'd7 - r_col_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_col_idx   <= '0;
        end else begin
            if (advance) r_out_valid <= ~i_q_stat.empty;
            if (emit)    r_col_idx   <= job_done ? 3'd0 : r_col_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_page_byte <= col_bits;
            r_column    <= {i_head.base, r_col_idx};
            r_page      <= i_head.page;
            r_last      <= i_head.last & job_done;
        end
    end

    assign o_page.valid     = r_out_valid;
    assign o_page.page_byte = r_page_byte;
    assign o_page.column    = r_column;
    assign o_page.page      = r_page;
    assign o_page.last      = r_last;

endmodule

// ===== rtl/row_to_page_bit_transpose_unit.sv =====
// Top level of the row-to-page bit transpose unit: register port, config
// clamping, front end, job queue and back end. Uses rptu_pkg and both channels.
//
// Usage: write window_width (0x0), window_height (0x4) and line_stride (0x8)
// through the APB port while the unit is idle, then stream the window one
// source byte per transfer on i_pix, row after row, each row one stride long.
// Bytes of the first rows of each 8-row page are kept in a 64 x 56 row store
// and produce nothing; each data byte of a page's final row yields up to eight
// page bytes on o_page, one per column, top pixel in bit 0, with last set on
// the window's final column. Padding bytes yield nothing.
// Throughput: i_pix takes one byte per cycle while the four-entry job queue
// has room; o_page delivers one page byte per cycle while ready is high, and
// a final-row byte yields one page byte per column, up to eight. The first
// page byte of a final-row byte passes the row store read register, the job
// queue and the output register; later columns follow one per cycle while
// o_page is ready. When o_page stalls, the output register holds, the queue
// fills and i_pix ready drops. Reset clears the position counters, queue and
// output valid and loads width 128, height 64, stride 0; the row store is not
// cleared.
module row_to_page_bit_transpose_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rptu_in_if.sink     i_pix,
    rptu_out_if.source  o_page,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [8:0] r_width;
    logic [8:0] r_height;
    logic [6:0] r_stride;

    logic [8:0] width_c;
    logic [8:0] height_c;
    logic [9:0] width_p7;
    logic [5:0] tight;
    logic [6:0] stride_c;

    rptu_pkg::t_cfg    cfg;
    rptu_pkg::t_job    push_job;
    rptu_pkg::t_job    head_job;
    rptu_pkg::t_q_stat q_stat;
    logic              push;
    logic              pop;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'd128;
            r_height <= 9'd64;
            r_stride <= 7'd0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                rptu_pkg::REG_WINDOW_WIDTH:  r_width  <= pwdata[8:0];
                rptu_pkg::REG_WINDOW_HEIGHT: r_height <= pwdata[8:0];
                rptu_pkg::REG_LINE_STRIDE:   r_stride <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            rptu_pkg::REG_WINDOW_WIDTH:  prdata = {23'd0, r_width};
            rptu_pkg::REG_WINDOW_HEIGHT: prdata = {23'd0, r_height};
            rptu_pkg::REG_LINE_STRIDE:   prdata = {25'd0, r_stride};
            default:                     prdata = '0;
        endcase
    end

    // Clamp zero to one and large values to the maxima; raise stride to tight
    assign width_c  = (r_width == 9'd0) ? 9'd1 :
                      (r_width > 9'(rptu_pkg::MAX_WIDTH)) ? 9'(rptu_pkg::MAX_WIDTH) : r_width;
    assign height_c = (r_height == 9'd0) ? 9'd1 :
                      (r_height > 9'(rptu_pkg::MAX_HEIGHT)) ? 9'(rptu_pkg::MAX_HEIGHT)
                                                            : r_height;
    assign width_p7 = {1'b0, width_c} + 10'd7;
    assign tight    = width_p7[8:3];
    assign stride_c = (r_stride > 7'(rptu_pkg::MAX_STRIDE)) ? 7'(rptu_pkg::MAX_STRIDE)
                                                            : r_stride;

    assign cfg.width     = width_c;
    assign cfg.height_m1 = 8'(height_c - 9'd1);
    assign cfg.tight     = tight;
    assign cfg.stride    = (stride_c < {1'b0, tight}) ? {1'b0, tight} : stride_c;

    rptu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_q_stat (q_stat),
        .i_pix    (i_pix),
        .o_push   (push),
        .o_job    (push_job)
    );

    rptu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_stat  (q_stat)
    );

    rptu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_job),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_page   (o_page)
    );

endmodule

// ===== tb/row_to_page_bit_transpose_unit_test.sv =====
// Self-checking testbench of the row-to-page bit transpose unit: streams windows of
// source bytes, predicts the vertical page bytes and compares every transfer.
// Depends on rptu_pkg, rptu_in_if, rptu_out_if and row_to_page_bit_transpose_unit.
`timescale 1ns / 100ps

module row_to_page_bit_transpose_unit_test;

    typedef struct packed {
        logic [7:0] page_byte;
        logic [7:0] column;
        logic [4:0] page;
        logic       last;
    } t_page_column;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rptu_in_if  pix_ch ();
    rptu_out_if page_ch ();

    row_to_page_bit_transpose_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_page  (page_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: configuration and position within the window
    logic [8:0]  cfg_width;
    logic [8:0]  cfg_height;
    logic [6:0]  cfg_stride;
    logic [55:0] row_bank [rptu_pkg::MAX_STRIDE];
    int          pos_row;
    int          pos_byte;
    logic [4:0]  pos_page;

    t_page_column pending_columns [$];
    t_page_column want_column;
    t_page_column got_column;
    int           fail_count;

    // Idle pattern state, one set per side
    bit force_steady;
    int in_left;
    bit in_calm;
    int out_left;
    bit out_calm;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    initial begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
    endfunction

    function automatic int clamp_size(input int v, input int hi);
        if (v == 0) begin
            return 1;
        end
        return (v > hi) ? hi : v;
    endfunction

    function automatic void effective_geometry(output int w, output int h,
                                               output int tight, output int stride);
        w      = clamp_size(cfg_width, rptu_pkg::MAX_WIDTH);
        h      = clamp_size(cfg_height, rptu_pkg::MAX_HEIGHT);
        tight  = (w + 7) / 8;
        stride = (cfg_stride > rptu_pkg::MAX_STRIDE) ? rptu_pkg::MAX_STRIDE : cfg_stride;
        if (stride < tight) begin
            stride = tight;
        end
    endfunction

    // Hold the upper rows of a page; on a final-row byte, emit one column per pixel
    function automatic void transpose_pixel_byte(input logic [7:0] pixel);
        int           w, h, tight, stride, r, b, i, k;
        bit           last_row, final_row;
        logic [63:0]  rows;
        t_page_column col;
        effective_geometry(w, h, tight, stride);
        r         = pos_row;
        b         = pos_byte;
        last_row  = (int'(pos_page) * 8 + r) >= h - 1;
        final_row = (r == 7) || last_row;
        if (b < tight) begin
            if (!final_row) begin
                row_bank[b][8*r +: 8] = pixel;
            end else begin
                rows = '0;
                for (k = 0; k < r; k++) begin
                    rows[8*k +: 8] = row_bank[b][8*k +: 8];
                end
                rows[8*r +: 8] = pixel;
                for (i = 0; i < 8 && b * 8 + i < w; i++) begin
                    col.page_byte = '0;
                    for (k = 0; k <= r; k++) begin
                        col.page_byte[k] = rows[8*k + 7 - i];
                    end
                    col.column = 8'(b * 8 + i);
                    col.page   = pos_page;
                    col.last   = last_row && (b * 8 + i == w - 1);
                    pending_columns.push_back(col);
                end
            end
        end
        if (b + 1 >= stride) begin
            pos_byte = 0;
            if (final_row) begin
                pos_row  = 0;
                pos_page = last_row ? 5'd0 : pos_page + 5'd1;
            end else begin
                pos_row = r + 1;
            end
        end else begin
            pos_byte = b + 1;
        end
    endfunction

    function automatic bit take_gap(inout int left, inout bit calm);
        if (force_steady) begin
            return 1'b0;
        end
        if (left == 0) begin
            calm = ($urandom_range(4) == 0);
            left = calm ? $urandom_range(150, 60) : $urandom_range(80, 20);
        end
        left--;
        return !calm && ($urandom_range(99) < 30);
    endfunction

    always @(negedge i_clk) begin
        page_ch.ready <= !take_gap(out_left, out_calm);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && page_ch.valid && page_ch.ready) begin
            got_column = '{page_ch.page_byte, page_ch.column, page_ch.page, page_ch.last};
            if (pending_columns.size() == 0) begin
                note_failure($sformatf("unexpected page byte %02h col %0d page %0d last %0b",
                    got_column.page_byte, got_column.column, got_column.page,
                    got_column.last));
            end else begin
                want_column = pending_columns.pop_front();
                if (got_column.page_byte !== want_column.page_byte ||
                    got_column.column !== want_column.column ||
                    got_column.page !== want_column.page ||
                    got_column.last !== want_column.last) begin
                    note_failure($sformatf(
                        "expected %02h col %0d page %0d last %0b, got %02h col %0d page %0d last %0b",
                        want_column.page_byte, want_column.column, want_column.page,
                        want_column.last, got_column.page_byte, got_column.column,
                        got_column.page, got_column.last));
                end
            end
        end
    end

    task automatic apb_access(input logic [1:0] index, input bit is_write,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = is_write;
        paddr   = {index, 2'b00};
        pwdata  = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        if (is_write) begin
            case (index)
                rptu_pkg::REG_WINDOW_WIDTH:  cfg_width  = wdata[8:0];
                rptu_pkg::REG_WINDOW_HEIGHT: cfg_height = wdata[8:0];
                rptu_pkg::REG_LINE_STRIDE:   cfg_stride = wdata[6:0];
                default: ;
            endcase
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_register(input logic [1:0] index, input logic [31:0] want);
        logic [31:0] value;
        apb_access(index, 1'b0, '0, value);
        if (value !== want) begin
            note_failure($sformatf("register %0d read %0h, expected %0h", index, value, want));
        end
    endtask

    task automatic write_register(input logic [1:0] index, input int value);
        logic [31:0] unused;
        apb_access(index, 1'b1, 32'(value), unused);
        case (index)
            rptu_pkg::REG_WINDOW_WIDTH:  check_register(index, 32'(cfg_width));
            rptu_pkg::REG_WINDOW_HEIGHT: check_register(index, 32'(cfg_height));
            default:                     check_register(index, 32'(cfg_stride));
        endcase
    endtask

    // Drain the outstanding page bytes, then let trailing padding bytes settle
    task automatic wait_idle();
        int guard;
        pix_ch.valid = 1'b0;
        guard = 0;
        while (pending_columns.size() != 0 && guard < 20000) begin
            @(negedge i_clk);
            guard++;
        end
        if (pending_columns.size() != 0) begin
            note_failure($sformatf("%0d page bytes never arrived", pending_columns.size()));
            pending_columns.delete();
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_window(input int w_reg, input int h_reg, input int s_reg);
        wait_idle();
        write_register(rptu_pkg::REG_WINDOW_WIDTH, w_reg);
        write_register(rptu_pkg::REG_WINDOW_HEIGHT, h_reg);
        write_register(rptu_pkg::REG_LINE_STRIDE, s_reg);
    endtask

    task automatic send_pixel_byte(input logic [7:0] pixel);
        while (take_gap(in_left, in_calm)) begin
            pix_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        pix_ch.valid      = 1'b1;
        pix_ch.pixel_byte = pixel;
        do @(posedge i_clk); while (!pix_ch.ready);
        transpose_pixel_byte(pixel);
        @(negedge i_clk);
    endtask

    task automatic stream_bytes(input logic [7:0] bytes [$]);
        foreach (bytes[n]) begin
            send_pixel_byte(bytes[n]);
        end
        pix_ch.valid = 1'b0;
    endtask

    // Stream one whole window of random bytes under the current settings
    task automatic stream_random_window(output int n_items);
        int         w, h, tight, stride;
        logic [7:0] bytes [$];
        effective_geometry(w, h, tight, stride);
        repeat (stride * h) bytes.push_back(8'($urandom_range(255)));
        stream_bytes(bytes);
        n_items = stride * h;
    endtask

    task automatic random_window(output int n_items);
        int sel, w_reg, h_reg, s_reg, tight;
        sel = $urandom_range(9);
        if (sel < 7) begin
            w_reg = $urandom_range(40, 1);
            h_reg = $urandom_range(20, 0);
        end else if (sel < 9) begin
            w_reg = $urandom_range(256, 41);
            h_reg = $urandom_range(3, 1);
        end else begin
            w_reg = $urandom_range(511, 0);
            h_reg = $urandom_range(2, 0);
        end
        tight = (clamp_size(w_reg, rptu_pkg::MAX_WIDTH) + 7) / 8;
        sel   = $urandom_range(9);
        if (sel < 5) begin
            s_reg = 0;
        end else if (sel < 8) begin
            s_reg = tight + $urandom_range(3);
        end else if (sel < 9) begin
            s_reg = $urandom_range(tight, 0);
        end else begin
            s_reg = $urandom_range(127, 65);
        end
        set_window(w_reg, h_reg, s_reg);
        stream_random_window(n_items);
    endtask

    task automatic test_register_defaults();
        check_register(rptu_pkg::REG_WINDOW_WIDTH, 32'd128);
        check_register(rptu_pkg::REG_WINDOW_HEIGHT, 32'd64);
        check_register(rptu_pkg::REG_LINE_STRIDE, 32'd0);
    endtask

    task automatic test_full_page();
        logic [7:0] bytes [$];
        set_window(8, 8, 0);
        bytes = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'h80, 8'h01, 8'h0F, 8'hF0};
        stream_bytes(bytes);
    endtask

    task automatic test_zero_sizes();
        logic [7:0] bytes [$];
        set_window(0, 0, 0);
        bytes = '{8'hFF};
        stream_bytes(bytes);
    endtask

    task automatic test_short_page_padding();
        logic [7:0] bytes [$];
        set_window(12, 3, 3);
        bytes = '{8'hF0, 8'hAB, 8'hC3, 8'h0F, 8'h54, 8'h3C, 8'hFF, 8'h80, 8'h77};
        stream_bytes(bytes);
    endtask

    task automatic test_stride_raised();
        logic [7:0] bytes [$];
        set_window(20, 2, 1);
        bytes = '{8'h81, 8'h7E, 8'hF5, 8'h18, 8'hE7, 8'h0A};
        stream_bytes(bytes);
    endtask

    // Width and stride above their limits, reaching column 255
    task automatic test_saturated_sizes();
        int unused;
        set_window(511, 1, 127);
        stream_random_window(unused);
    endtask

    // Height above its limit, walking all 32 pages with no idling on either side
    task automatic test_tall_window();
        int unused;
        set_window(3, 511, 0);
        force_steady = 1'b1;
        stream_random_window(unused);
        wait_idle();
        force_steady = 1'b0;
    endtask

    task automatic test_random_windows();
        int total, n;
        total = 0;
        while (total < 24) begin
            random_window(n);
            total += n;
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        pix_ch.valid      = 1'b0;
        pix_ch.pixel_byte = '0;
        page_ch.ready     = 1'b0;
        fail_count        = 0;
        force_steady      = 1'b0;
        in_left           = 0;
        out_left          = 0;
        cfg_width         = 9'd128;
        cfg_height        = 9'd64;
        cfg_stride        = 7'd0;
        pos_row           = 0;
        pos_byte          = 0;
        pos_page          = '0;
        foreach (row_bank[n]) begin
            row_bank[n] = '0;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_register_defaults();
        test_full_page();
        test_zero_sizes();
        test_short_page_padding();
        test_stride_raised();
        test_saturated_sizes();
        test_tall_window();
        test_random_windows();
        wait_idle();

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rptu_pkg.sv
rtl/rptu_in_if.sv
rtl/rptu_out_if.sv
rtl/rptu_front.sv
rtl/rptu_queue.sv
rtl/rptu_back.sv
rtl/row_to_page_bit_transpose_unit.sv
tb/row_to_page_bit_transpose_unit_test.sv
